// ===== hdl/fascp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fascp_pkg: shared types and constants
// Byte codes, frame layout, command codes and queue sizing for the framed
// ASCII speed command parser.
// ----------------------------------------------------------------------------
package fascp_pkg;

  localparam int unsigned BUFFER_LENGTH_DEFAULT = 100;
  localparam int unsigned KEPT_BYTES            = 9;
  localparam int unsigned POS_W                 = 7;
  localparam int unsigned FRAME_QUEUE_DEPTH     = 2;

  localparam logic [7:0] START_MARK      = 8'h3C;  // '<'
  localparam logic [7:0] END_MARK        = 8'h3E;  // '>'
  localparam logic [7:0] LETTER_POSITIVE = 8'h41;  // 'A'
  localparam logic [7:0] LETTER_MOVE     = 8'h4D;  // 'M'
  localparam logic [7:0] LETTER_SPIN     = 8'h56;  // 'V'
  localparam logic [7:0] DIGIT_ZERO      = 8'h30;  // '0'

  typedef logic [KEPT_BYTES-1:0][7:0] frame_t;

  typedef enum logic [1:0] {
    CMD_UNKNOWN = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_SPIN    = 2'd2
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/fascp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fascp_front: byte intake
// Track the write position, keep the first nine payload bytes and hand a
// snapshot of them to the frame queue on each end mark.
// ----------------------------------------------------------------------------
module fascp_front
  import fascp_pkg::*;
#(
  parameter int unsigned BUFFER_LENGTH = BUFFER_LENGTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       frame_push,
  output frame_t     frame
);

  localparam logic [POS_W:0] LastPos = (POS_W + 1)'(BUFFER_LENGTH - 1);

  frame_t            field_bytes;
  logic [POS_W-1:0]  write_position;

  assign frame      = field_bytes;
  assign frame_push = accept && (rx_byte == END_MARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_bytes    <= '0;
      write_position <= '0;
    end else if (accept) begin
      if (rx_byte == START_MARK) begin
        write_position <= '0;
      end else if (rx_byte != END_MARK) begin
        // drop bytes past the kept window, but still advance
        if (write_position < POS_W'(KEPT_BYTES)) begin
          field_bytes[write_position[3:0]] <= rx_byte;
        end
        if ({1'b0, write_position} == LastPos) begin
          write_position <= '0;
        end else begin
          write_position <= write_position + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/fascp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fascp_queue: frame queue
// Short first-in first-out store of frame snapshots between front and back.
// ----------------------------------------------------------------------------
module fascp_queue
  import fascp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  frame_t        wr_data,
  input  logic          rd_en,
  output frame_t        rd_data,
  output queue_status_t status
);

  localparam int unsigned PtrW = (FRAME_QUEUE_DEPTH > 1) ? $clog2(FRAME_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FRAME_QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FRAME_QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FRAME_QUEUE_DEPTH);

  frame_t          entries [FRAME_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fascp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fascp_back: frame decoder
// Decode the oldest queued frame into a command and two targets, and hold
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module fascp_back
  import fascp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  frame_t             frame,
  input  queue_status_t      q_status,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         command,
  output logic signed [15:0] first_target,
  output logic signed [15:0] second_target
);

  // '0' weight of the three digits, taken off in one step
  localparam logic [15:0] DigitBias = 16'(int'(DIGIT_ZERO) * 111);

  function automatic logic [15:0] make_target(input logic [7:0] dir,
                                              input logic [7:0] h,
                                              input logic [7:0] t,
                                              input logic [7:0] u);
    logic [15:0] mag;
    mag = ({8'd0, h} * 16'd100) + ({8'd0, t} * 16'd10) + {8'd0, u} - DigitBias;
    if (dir != LETTER_POSITIVE) begin
      mag = 16'd0 - mag;
    end
    return mag;
  endfunction

  logic        out_valid;
  cmd_t        cmd_next;
  logic [15:0] first_next;
  logic [15:0] second_next;

  assign empty = !out_valid;
  assign q_pop = !q_status.empty && (!out_valid || pop);

  always_comb begin
    cmd_next    = CMD_UNKNOWN;
    first_next  = '0;
    second_next = '0;
    if (frame[0] == LETTER_MOVE) begin
      cmd_next    = CMD_MOVE;
      first_next  = make_target(frame[1], frame[2], frame[3], frame[4]);
      second_next = make_target(frame[5], frame[6], frame[7], frame[8]);
    end else if (frame[0] == LETTER_SPIN) begin
      cmd_next   = CMD_SPIN;
      first_next = make_target(frame[1], frame[2], frame[3], frame[4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      command       <= cmd_next;
      first_target  <= signed'(first_next);
      second_target <= signed'(second_next);
    end
  end

endmodule

// ===== hdl/framed_ascii_speed_command_parser.sv =====
`timescale 1ns / 1ps
// A '>' is written into the frame queue, then decoded into the output register, which drives empty low.
// Throughput: one byte per cycle while full is low; the front stores bytes while the back decodes.
// A two-entry frame queue lets the front keep taking bytes while a result waits.
// full rises only when that queue holds two frames not yet decoded.
// Reset (rst, synchronous) clears the nine kept bytes, the write position,
// the frame queue and the output valid flag; the output data is not reset.
// ----------------------------------------------------------------------------
// framed_ascii_speed_command_parser: top level
// Frames '<' ... '>' byte streams and decodes move and spin rate commands.
// ----------------------------------------------------------------------------
module framed_ascii_speed_command_parser
  import fascp_pkg::*;
#(
  parameter int unsigned BUFFER_LENGTH = BUFFER_LENGTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // byte intake
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  // decoded results
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         command,
  output logic signed [15:0] first_target,
  output logic signed [15:0] second_target
);

  logic          accept;
  logic          frame_push;
  frame_t        frame_in;
  frame_t        frame_out;
  logic          q_pop;
  queue_status_t q_status;

  // Hold all bytes while the queue is full, so an end mark never gets lost.
  assign full   = q_status.full;
  assign accept = push && !full;

  // Front: track position and snapshot the kept bytes at each end mark.
  fascp_front #(
    .BUFFER_LENGTH(BUFFER_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .frame_push(frame_push),
    .frame     (frame_in)
  );

  // Queue: decouple intake from decode.
  fascp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (frame_push),
    .wr_data(frame_in),
    .rd_en  (q_pop),
    .rd_data(frame_out),
    .status (q_status)
  );

  // Back: decode the oldest frame into the output register.
  fascp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame_out),
    .q_status     (q_status),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .command      (command),
    .first_target (first_target),
    .second_target(second_target)
  );

  // An unknown letter carries no targets.
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && command == CMD_UNKNOWN) |-> (first_target == 0 && second_target == 0))
    else $error("unknown command with nonzero target");

  // A spin rate command carries no second target.
  a_spin_second_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && command == CMD_SPIN) |-> (second_target == 0))
    else $error("spin command with nonzero second target");

  // An accepted end mark is held somewhere after the edge.
  a_frame_kept: assert property (@(posedge clk) disable iff (rst)
    (accept && rx_byte == END_MARK) |=> (!q_status.empty || !empty))
    else $error("end mark accepted but no frame pending");

endmodule
